FILE: rtl/ils_pkg.sv
package ils_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_FIND   = 3'd2,
    FN_GET    = 3'd3,
    FN_UPDATE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  position;
    logic [63:0] word_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_at;
    logic [63:0] word_out;
    logic [6:0]  count;
  } rsp_t;

  // broadcast to every cell for the item being accepted
  typedef struct packed {
    logic                 load;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 upd_ok;
    logic                 find;
    logic                 get;
    logic [6:0]           pos;
    logic [CNT_W-1:0]     fill;
    logic [WORD_BITS-1:0] word;
  } cmd_t;

endpackage

FILE: rtl/ils_cell.sv
module ils_cell (
  input  logic                         clk,
  input  ils_pkg::cmd_t                cmd,
  input  logic [ils_pkg::IDX_W-1:0]    idx,
  input  logic [ils_pkg::WORD_BITS-1:0] left_word,
  input  logic [ils_pkg::WORD_BITS-1:0] right_word,
  output logic [ils_pkg::WORD_BITS-1:0] word,
  output logic                         hit
);
  import ils_pkg::*;

  logic [6:0] my_pos;
  logic       above, at, live;
  logic       hit_next;

  assign my_pos = 7'(idx);
  assign above  = my_pos > cmd.pos;
  assign at     = my_pos == cmd.pos;
  assign live   = CNT_W'(idx) < cmd.fill;

  assign hit_next = (cmd.find && live && (word == cmd.word)) ||
                    (cmd.get && at && live);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit <= hit_next;
      if (cmd.ins_ok && above) begin
        word <= left_word;
      end else if (cmd.del_ok && (above || at)) begin
        word <= right_word;
      end else if ((cmd.ins_ok || cmd.upd_ok) && at) begin
        word <= cmd.word;
      end
    end
  end

endmodule

FILE: rtl/ils_reduce.sv
module ils_reduce (
  input  logic [ils_pkg::CAPACITY-1:0]  hits,
  input  logic [ils_pkg::WORD_BITS-1:0] words [ils_pkg::CAPACITY],
  output logic                          any,
  output logic [ils_pkg::IDX_W-1:0]     first,
  output logic [ils_pkg::WORD_BITS-1:0] sel_word
);
  import ils_pkg::*;

  // lowest set hit wins
  always_comb begin
    first = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first = IDX_W'(i);
      end
    end
  end

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | (words[i] & {WORD_BITS{hits[i]}});
    end
  end

  assign any = |hits;

endmodule

FILE: rtl/indexed_list_store.sv
// Ordered list of 64-bit words held in a row of 64 cells.
// The cells register the accepted item, then the find/get reduction feeds the
// output register.
// Throughput: one item per cycle; req_stall rises only when the reduction
// stage is full and the output register is held by rsp_stall.
// Reset: clears the entry count and the handshake state; cell words are
// undefined until written.
module indexed_list_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ils_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  // entry count
  logic [CNT_W-1:0] fill, fill_next;

  // item decode
  logic    accept;
  cmd_t    cmd;
  status_t status_now;
  logic    in_range, pos_ok_ins;

  // cell row
  logic [WORD_BITS-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]  hits;

  // reduction stage
  logic             red_v;
  logic             red_find;
  logic             red_get;
  status_t          red_status;
  logic [CNT_W-1:0] red_count;
  logic             red_go;

  logic                 any;
  logic [IDX_W-1:0]     first;
  logic [WORD_BITS-1:0] sel_word;

  // Output register takes the reduction stage when empty or being drained;
  // the cells can take a new item whenever the reduction stage moves on.
  assign red_go    = red_v && (!rsp_valid || !rsp_stall);
  assign req_stall = red_v && !red_go;
  assign accept    = req_valid && !req_stall;

  assign in_range   = 7'(fill) > req.position;
  assign pos_ok_ins = req.position <= 7'(fill);

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.pos    = req.position;
    cmd.fill   = fill;
    cmd.word   = req.word_in[WORD_BITS-1:0];
    status_now = ST_OK;
    fill_next  = fill;
    unique case (req.func)
      FN_INSERT: begin
        if (!pos_ok_ins) begin
          status_now = ST_RANGE;
        end else if (fill >= CNT_W'(CAPACITY)) begin
          status_now = ST_FULL;
        end else begin
          cmd.ins_ok = 1'b1;
          fill_next  = fill + CNT_W'(1);
        end
      end
      FN_DELETE: begin
        if (!in_range) begin
          status_now = ST_RANGE;
        end else begin
          cmd.del_ok = 1'b1;
          fill_next  = fill - CNT_W'(1);
        end
      end
      FN_FIND: begin
        cmd.find   = 1'b1;
        status_now = ST_MISSING;
      end
      FN_GET: begin
        cmd.get = 1'b1;
        if (!in_range) status_now = ST_RANGE;
      end
      FN_UPDATE: begin
        if (!in_range) begin
          status_now = ST_RANGE;
        end else begin
          cmd.upd_ok = 1'b1;
        end
      end
      default: begin
        status_now = ST_RANGE;
      end
    endcase
  end

  // Insert: above pos takes left word. Delete: pos and above take right word.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] lw, rw;
    if (i == 0) begin : g_first
      assign lw = cmd.word;
    end else begin : g_mid_l
      assign lw = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rw = words[i];
    end else begin : g_mid_r
      assign rw = words[i+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .left_word  (lw),
      .right_word (rw),
      .word       (words[i]),
      .hit        (hits[i])
    );
  end

  // Find and get pick from the registered hit flags; cells cannot change
  // underneath because a stalled reduction stage holds off new items.
  ils_reduce u_reduce (
    .hits     (hits),
    .words    (words),
    .any      (any),
    .first    (first),
    .sel_word (sel_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      red_v     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill  <= fill_next;
        red_v <= 1'b1;
      end else if (red_go) begin
        red_v <= 1'b0;
      end
      if (red_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_find   <= cmd.find;
      red_get    <= cmd.get && (status_now == ST_OK);
      red_status <= status_now;
      red_count  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (red_go) begin
      rsp.count    <= 7'(red_count);
      rsp.word_out <= red_get ? 64'(sel_word) : '0;
      if (red_find) begin
        rsp.status   <= any ? ST_OK : ST_MISSING;
        rsp.found_at <= any ? 6'(first) : '0;
      end else begin
        rsp.status   <= red_status;
        rsp.found_at <= '0;
      end
    end
  end

endmodule

FILE: rtl/ils_check.sv
module ils_check (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  // a held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= 7'(CAPACITY))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == 7'(CAPACITY))
    else $error("full flagged on a list that is not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.found_at == '0) && (rsp.word_out == '0))
    else $error("failed item carries data");

endmodule

bind indexed_list_store ils_check u_check (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ils_pkg::*;

  // Operation codes the block does not define; they must report an index error.
  localparam logic [2:0]  FN_UNUSED_LO = 3'd5;
  localparam logic [2:0]  FN_UNUSED_HI = 3'd7;

  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam logic [63:0] PATTERN_A = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] PATTERN_B = 64'h5a5a_a5a5_5a5a_a5a5;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int PHASE_LEN      = 150;
  localparam int IDLE_PCT       = 14;
  // Longest stretch without any item moving on either side, set far above what
  // correct traffic produces.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  indexed_list_store i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Shadow copy of the list, advanced once per item in send order.
  logic [WORD_BITS-1:0] list_words [CAPACITY];
  int unsigned          list_fill;

  rsp_t expected_rsps [$];
  rsp_t want_rsp;

  // Directed rows: a typed expectation where it is obvious, else predicted.
  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } stim_row_t;
  stim_row_t directed_rows [$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  rsps_checked = 0;
  int  idle_cycles  = 0;
  int  peak_fill    = 0;
  int  status_tally [4];
  int  insert_pct   = 60;
  int  delete_pct   = 8;
  bit  no_idle      = 1'b0;

  // Next state of the list and the result for one item.
  function automatic rsp_t list_apply(input req_t r);
    rsp_t        o;
    int unsigned p;
    int unsigned i;
    o = '0;
    o.status = ST_OK;
    p = r.position;
    case (r.func)
      FN_INSERT: begin
        if (p > list_fill) begin
          o.status = ST_RANGE;
        end else if (list_fill >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_fill; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = r.word_in[WORD_BITS-1:0];
          list_fill++;
        end
      end
      FN_DELETE: begin
        if (p >= list_fill) begin
          o.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
          list_fill--;
        end
      end
      FN_FIND: begin
        // Raw bit compare: +0 and -0 are different words.
        o.status = ST_MISSING;
        for (i = 0; i < list_fill; i++) begin
          if (list_words[i] == r.word_in[WORD_BITS-1:0]) begin
            o.status = ST_OK;
            o.found_at = 6'(i);
            break;
          end
        end
      end
      FN_GET: begin
        if (p >= list_fill) o.status = ST_RANGE;
        else o.word_out = 64'(list_words[p]);
      end
      FN_UPDATE: begin
        if (p >= list_fill) o.status = ST_RANGE;
        else list_words[p] = r.word_in[WORD_BITS-1:0];
      end
      default: o.status = ST_RANGE;
    endcase
    o.count = 7'(list_fill);
    return o;
  endfunction

  // Random item, mostly well-formed against the current list contents.
  function automatic req_t pick_item();
    req_t        r;
    int unsigned roll;
    int unsigned hit_pct;
    roll = $urandom_range(99);
    if (roll < 4) begin
      r.func = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    end else if (roll < 4 + insert_pct) begin
      r.func = FN_INSERT;
    end else if (roll < 4 + insert_pct + delete_pct) begin
      r.func = FN_DELETE;
    end else begin
      case ($urandom_range(2))
        0:       r.func = FN_FIND;
        1:       r.func = FN_GET;
        default: r.func = FN_UPDATE;
      endcase
    end

    roll = $urandom_range(99);
    if (roll < 8) r.position = 7'($urandom_range(127));
    else if (r.func == FN_INSERT) r.position = 7'($urandom_range(list_fill));
    else if (list_fill > 0) r.position = 7'($urandom_range(list_fill - 1));
    else r.position = '0;

    // Reuse stored words so finds hit and duplicates show up.
    hit_pct = (r.func == FN_FIND) ? 60 : 20;
    roll = $urandom_range(99);
    if (list_fill > 0 && roll < hit_pct) begin
      r.word_in = 64'(list_words[$urandom_range(list_fill - 1)]);
    end else if (roll < 70) begin
      r.word_in = {$urandom, $urandom};
    end else begin
      case ($urandom_range(3))
        0:       r.word_in = '0;
        1:       r.word_in = NEG_ZERO;
        2:       r.word_in = ALL_ONES;
        default: r.word_in = 64'($urandom_range(3));
      endcase
    end
    return r;
  endfunction

  // Present one item, record its expectation, hold it until taken.
  task automatic send_item(input req_t item, input bit typed, input rsp_t typed_rsp);
    rsp_t model_rsp;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    model_rsp = list_apply(item);
    expected_rsps.push_back(typed ? typed_rsp : model_rsp);
    status_tally[model_rsp.status]++;
    if (list_fill > peak_fill) peak_fill = list_fill;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic wait_results_home();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rsps.size() != 0);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // Result checker: oldest expectation first, every field.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no item outstanding: %p", rsp);
        fail_count++;
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (rsp.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
          fail_count++;
        end
        if (rsp.found_at !== want_rsp.found_at) begin
          $error("found_at: expected %0d, got %0d", want_rsp.found_at, rsp.found_at);
          fail_count++;
        end
        if (rsp.word_out !== want_rsp.word_out) begin
          $error("word_out: expected %h, got %h", want_rsp.word_out, rsp.word_out);
          fail_count++;
        end
        if (rsp.count !== want_rsp.count) begin
          $error("count: expected %0d, got %0d", want_rsp.count, rsp.count);
          fail_count++;
        end
      end
      rsps_checked++;
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[indexed_list_store] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Empty list: every indexed access is out of range, find misses.
    directed_rows.push_back('{req_t'{FN_FIND, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_MISSING, 6'd0, 64'd0, 7'd0}});
    directed_rows.push_back('{req_t'{FN_GET, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd0}});
    directed_rows.push_back('{req_t'{FN_DELETE, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd0}});
    directed_rows.push_back('{req_t'{FN_UPDATE, 7'd0, ALL_ONES}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd0}});
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd1, ALL_ONES}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd0}});
    // +0 and -0 must stay distinct for find.
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_OK, 6'd0, 64'd0, 7'd1}});
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd1, NEG_ZERO}, 1'b1,
                              rsp_t'{ST_OK, 6'd0, 64'd0, 7'd2}});
    directed_rows.push_back('{req_t'{FN_FIND, 7'd0, NEG_ZERO}, 1'b1,
                              rsp_t'{ST_OK, 6'd1, 64'd0, 7'd2}});
    directed_rows.push_back('{req_t'{FN_FIND, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_OK, 6'd0, 64'd0, 7'd2}});
    // Insert at the head shifts everything up.
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd0, ALL_ONES}, 1'b1,
                              rsp_t'{ST_OK, 6'd0, 64'd0, 7'd3}});
    directed_rows.push_back('{req_t'{FN_GET, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_OK, 6'd0, ALL_ONES, 7'd3}});
    directed_rows.push_back('{req_t'{FN_GET, 7'd2, 64'd0}, 1'b1,
                              rsp_t'{ST_OK, 6'd0, NEG_ZERO, 7'd3}});
    directed_rows.push_back('{req_t'{FN_GET, 7'd3, 64'd0}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd3}});
    // Undefined op codes and the largest index.
    directed_rows.push_back('{req_t'{FN_UNUSED_LO, 7'd0, 64'd0}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd3}});
    directed_rows.push_back('{req_t'{FN_UNUSED_HI, 7'd127, ALL_ONES}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd3}});
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd127, ALL_ONES}, 1'b1,
                              rsp_t'{ST_RANGE, 6'd0, 64'd0, 7'd3}});
    // Append, duplicate, overwrite, delete from both ends.
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd3, PATTERN_A}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_INSERT, 7'd2, ALL_ONES}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_FIND, 7'd0, ALL_ONES}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_UPDATE, 7'd0, PATTERN_B}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_FIND, 7'd0, ALL_ONES}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_DELETE, 7'd4, 64'd0}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_DELETE, 7'd0, 64'd0}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_FIND, 7'd0, PATTERN_A}, 1'b0, rsp_t'('0)});
    directed_rows.push_back('{req_t'{FN_UPDATE, 7'd64, PATTERN_A}, 1'b0, rsp_t'('0)});

    list_fill = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end

    // Random part: alternate growing, shrinking and mixed phases so the list
    // swings between empty and full. One quiet stretch with no idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0 || n == 600 || n == 1000) wait_results_home();
      no_idle = (n >= 900 && n < 1200);
      case ((n / PHASE_LEN) % 3)
        0: begin
          insert_pct = 60;
          delete_pct = 8;
        end
        1: begin
          insert_pct = 10;
          delete_pct = 55;
        end
        default: begin
          insert_pct = 30;
          delete_pct = 25;
        end
      endcase
      send_item(pick_item(), 1'b0, rsp_t'('0));
    end

    wait_results_home();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results; ok %0d, range %0d, full %0d, missing %0d.",
             items_sent, rsps_checked, status_tally[ST_OK], status_tally[ST_RANGE],
             status_tally[ST_FULL], status_tally[ST_MISSING]);
    $display("List depth peaked at %0d of %0d entries.", peak_fill, CAPACITY);
    if (fail_count == 0) begin
      $display("[indexed_list_store] OK");
    end else begin
      $display("[indexed_list_store] ERROR");
    end
    $finish;
  end

endmodule

FILE: indexed_list_store.f
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_reduce.sv
rtl/indexed_list_store.sv
rtl/ils_check.sv
sim/testbench.sv
